// ----- hdl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define DCLC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dclc check failed");

// Checked on every clock edge, reset included.
`define DCLC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dclc reset check failed");

`endif

// ----- hdl/dclc_pkg.sv -----
package dclc_pkg;

  localparam int RATIO_FRAC_BITS_DEF = 10;
  localparam int LUX_FRAC_BITS_DEF   = 10;

  localparam int COUNT_W = 16;
  localparam int LUX_W   = 21;
  localparam logic [LUX_W-1:0] LUX_MAX = '1;

  // Coefficients are Q16.
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_W = 12;
  localparam logic [3:0][COEF_W-1:0] COEF_A = {12'd96, 12'd839, 12'd1468, 12'd1992};
  localparam logic [3:0][COEF_W-1:0] COEF_B = {12'd73, 12'd1003, 12'd2032, 12'd4063};

  // Band limits in percent of unity ratio.
  localparam int LIMIT_PCT_0 = 50;
  localparam int LIMIT_PCT_1 = 61;
  localparam int LIMIT_PCT_2 = 80;
  localparam int LIMIT_PCT_3 = 130;

  // The power table is indexed in 1/1024 steps up to a ratio of one half.
  localparam int ROM_FRAC_BITS = 10;
  localparam int ROM_LAST      = 512;
  localparam int ROM_IDX_W     = 10;
  localparam int ROM_DATA_W    = 16;

  // Depth of the result queue; it covers the back end's three stages, the queue
  // itself and the consumer's pop, so credits return in time for one request
  // per clock while the consumer keeps taking results.
  localparam int OUTQ_DEPTH = 5;

  typedef enum logic [2:0] {
    BAND_LOW   = 3'd0,
    BAND_MID   = 3'd1,
    BAND_HIGH  = 3'd2,
    BAND_TOP   = 3'd3,
    BAND_ABOVE = 3'd4,
    BAND_DARK  = 3'd5
  } band_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   ch0;
    logic [COUNT_W-1:0]   ch1;
    logic [ROM_IDX_W-1:0] rom_idx;
    band_t                band;
  } front_item_t;

  typedef struct packed {
    logic [LUX_W-1:0] lux;
    band_t            band;
  } result_t;

  typedef logic [ROM_LAST:0][ROM_DATA_W-1:0] pow_rom_t;

  // Largest y with y == 0 or (2y-1)^5 <= 2^15 * i^7, which is
  // round(65536 * (i/1024)^1.4). Evaluated at elaboration only.
  function automatic logic [ROM_DATA_W-1:0] pow14_entry(input int unsigned i);
    logic [95:0] rhs;
    logic [95:0] lhs;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    rhs = 96'(1) << 15;
    for (int k = 0; k < 7; k++) begin
      rhs = rhs * 96'(i);
    end
    lo = 0;
    hi = 65535;
    for (int s = 0; s < 17; s++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 1) >> 1);
        lhs = 96'(1);
        for (int k = 0; k < 5; k++) begin
          lhs = lhs * 96'(2 * mid - 1);
        end
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return ROM_DATA_W'(lo);
  endfunction

  function automatic pow_rom_t build_pow_rom();
    pow_rom_t rom;
    for (int i = 0; i <= ROM_LAST; i++) begin
      rom[i] = pow14_entry(i);
    end
    return rom;
  endfunction

  localparam pow_rom_t POW_ROM = build_pow_rom();

endpackage

// ----- hdl/dclc_queue.sv -----
module dclc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  import dclc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign rdata  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ptr_inc(wptr);
      end
      if (do_pop) begin
        rptr <= ptr_inc(rptr);
      end
      count <= count + CW'(push) - CW'(do_pop);
    end
  end

endmodule

// ----- hdl/dclc_front.sv -----
module dclc_front #(
  parameter int RATIO_FRAC_BITS = dclc_pkg::RATIO_FRAC_BITS_DEF,
  parameter int QDEPTH          = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [dclc_pkg::COUNT_W-1:0] broadband_count,
  input  logic [dclc_pkg::COUNT_W-1:0] infrared_count,
  output logic                         full,
  input  logic                         credit_ret,
  output logic                         item_valid,
  output dclc_pkg::front_item_t        item
);
  import dclc_pkg::*;

  localparam int QB   = RATIO_FRAC_BITS + 2;
  localparam int CW   = $clog2(QDEPTH + 1);
  localparam int UP   = (RATIO_FRAC_BITS < ROM_FRAC_BITS) ? ROM_FRAC_BITS - RATIO_FRAC_BITS : 0;
  localparam int DOWN = (RATIO_FRAC_BITS > ROM_FRAC_BITS) ? RATIO_FRAC_BITS - ROM_FRAC_BITS : 0;
  localparam int RXW  = 18;

  localparam logic [QB-1:0] LIM_0 = QB'((LIMIT_PCT_0 << RATIO_FRAC_BITS) / 100);
  localparam logic [QB-1:0] LIM_1 = QB'((LIMIT_PCT_1 << RATIO_FRAC_BITS) / 100);
  localparam logic [QB-1:0] LIM_2 = QB'((LIMIT_PCT_2 << RATIO_FRAC_BITS) / 100);
  localparam logic [QB-1:0] LIM_3 = QB'((LIMIT_PCT_3 << RATIO_FRAC_BITS) / 100);

  logic               vld  [0:QB];
  logic [COUNT_W-1:0] ch0  [0:QB];
  logic [COUNT_W-1:0] ch1  [0:QB];
  logic [COUNT_W-1:0] rem  [0:QB];
  logic [QB-1:0]      quo  [0:QB];
  logic               dark [0:QB];
  logic               over [0:QB];

  logic          accept;
  logic [CW-1:0] used;
  logic [CW-1:0] used_next;

  assign accept = push && !full;
  assign full   = (used == CW'(QDEPTH));

  // Requests accepted but not yet taken by the back end out of the queue.
  assign used_next = used + CW'(accept) - CW'(credit_ret);

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used_next;
    end
  end

  // Entry stage: the remainder starts from the top of ch1 * 2^R.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    ch0[0]  <= broadband_count;
    ch1[0]  <= infrared_count;
    rem[0]  <= {2'b00, infrared_count[COUNT_W-1:2]};
    quo[0]  <= '0;
    dark[0] <= (broadband_count == '0);
    over[0] <= ({broadband_count, 2'b00} <= {2'b00, infrared_count});
  end

  // One restoring division step per stage, most significant quotient bit first.
  for (genvar k = 1; k <= QB; k++) begin : g_step
    localparam int J = QB - k;
    logic        dbit;
    logic [16:0] trial;
    logic        fits;

    if (J == RATIO_FRAC_BITS + 1) begin : g_b1
      assign dbit = ch1[k-1][1];
    end else if (J == RATIO_FRAC_BITS) begin : g_b0
      assign dbit = ch1[k-1][0];
    end else begin : g_bz
      assign dbit = 1'b0;
    end

    assign trial = {rem[k-1], dbit};
    assign fits  = (trial >= {1'b0, ch0[k-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      ch0[k]  <= ch0[k-1];
      ch1[k]  <= ch1[k-1];
      dark[k] <= dark[k-1];
      over[k] <= over[k-1];
      rem[k]  <= fits ? COUNT_W'(trial - {1'b0, ch0[k-1]}) : trial[COUNT_W-1:0];
      if (QB > 1) begin
        quo[k] <= {quo[k-1][QB-2:0], fits};
      end else begin
        quo[k] <= fits;
      end
    end
  end

  logic [QB-1:0]        ratio;
  logic [RXW-1:0]       ratio_x;
  logic [ROM_IDX_W-1:0] idx;
  band_t                band;

  always_comb begin
    ratio   = over[QB] ? '1 : quo[QB];
    ratio_x = RXW'(ratio);
    idx     = ROM_IDX_W'((ratio_x << UP) >> DOWN);
    if (dark[QB]) begin
      band = BAND_DARK;
    end else if (ratio <= LIM_0) begin
      band = BAND_LOW;
    end else if (ratio <= LIM_1) begin
      band = BAND_MID;
    end else if (ratio <= LIM_2) begin
      band = BAND_HIGH;
    end else if (ratio <= LIM_3) begin
      band = BAND_TOP;
    end else begin
      band = BAND_ABOVE;
    end
  end

  assign item_valid = vld[QB];
  assign item       = '{ch0: ch0[QB], ch1: ch1[QB], rom_idx: idx, band: band};

endmodule

// ----- hdl/dclc_back.sv -----
module dclc_back #(
  parameter int LUX_FRAC_BITS = dclc_pkg::LUX_FRAC_BITS_DEF,
  parameter int QDEPTH        = dclc_pkg::OUTQ_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  src_empty,
  input  dclc_pkg::front_item_t src_item,
  output logic                  src_pop,
  input  logic                  res_ret,
  output logic                  res_valid,
  output dclc_pkg::result_t     res
);
  import dclc_pkg::*;

  localparam int CW    = $clog2(QDEPTH + 1);
  localparam int SHIFT = 2 * COEF_FRAC_BITS - LUX_FRAC_BITS;
  localparam int XW    = 30;
  localparam int AW    = 47;

  logic          issue;
  logic [CW-1:0] used;
  logic [CW-1:0] used_next;

  assign issue     = !src_empty && (used < CW'(QDEPTH));
  assign src_pop   = issue;
  assign used_next = used + CW'(issue) - CW'(res_ret);

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used_next;
    end
  end

  // Stage 1: power table read.
  logic                  v1;
  logic [COUNT_W-1:0]    ch0_1;
  logic [COUNT_W-1:0]    ch1_1;
  band_t                 band_1;
  logic [ROM_DATA_W-1:0] p_1;
  logic [ROM_IDX_W-1:0]  rom_sel;

  assign rom_sel = (src_item.rom_idx > ROM_IDX_W'(ROM_LAST)) ? ROM_IDX_W'(ROM_LAST)
                                                              : src_item.rom_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= issue;
    end
  end

  always_ff @(posedge clk) begin
    ch0_1  <= src_item.ch0;
    ch1_1  <= src_item.ch1;
    band_1 <= src_item.band;
    p_1    <= POW_ROM[rom_sel];
  end

  // Stage 2: coefficient products.
  logic                 v2;
  logic [COUNT_W-1:0]   ch0_2;
  logic                 low_2;
  band_t                band_2;
  logic signed [XW-1:0] x_2;

  logic [2:0]           bcode;
  logic                 low_1;
  logic                 formula;
  logic [28:0]          pa;
  logic [28:0]          pb;
  logic signed [XW-1:0] x_next;

  always_comb begin
    bcode   = band_1;
    low_1   = (band_1 == BAND_LOW);
    formula = band_1 inside {BAND_LOW, BAND_MID, BAND_HIGH, BAND_TOP};
    pa      = low_1 ? (29'(COEF_A[0]) << COEF_FRAC_BITS)
                    : 29'(COEF_A[bcode[1:0]]) * 29'(ch0_1);
    pb      = 29'(COEF_B[bcode[1:0]]) * 29'(low_1 ? p_1 : ch1_1);
    x_next  = formula ? ($signed({1'b0, pa}) - $signed({1'b0, pb})) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    ch0_2  <= ch0_1;
    low_2  <= low_1;
    band_2 <= band_1;
    x_2    <= x_next;
  end

  // Stage 3: Q32 accumulator.
  logic                 v3;
  band_t                band_3;
  logic signed [AW-1:0] acc_3;
  logic signed [AW-1:0] prod;
  logic signed [AW-1:0] x_w;

  assign prod = $signed({1'b0, ch0_2}) * x_2;
  assign x_w  = AW'(x_2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    band_3 <= band_2;
    acc_3  <= low_2 ? prod : (x_w <<< COEF_FRAC_BITS);
  end

  // Clamp at zero, scale, saturate.
  logic [AW-1:0]    mag;
  logic [AW-1:0]    shifted;
  logic [LUX_W-1:0] lux;

  always_comb begin
    mag     = acc_3;
    shifted = mag >> SHIFT;
    if (acc_3[AW-1] || (acc_3 == '0)) begin
      lux = '0;
    end else if (shifted > AW'(LUX_MAX)) begin
      lux = LUX_MAX;
    end else begin
      lux = shifted[LUX_W-1:0];
    end
  end

  assign res_valid = v3;
  assign res       = '{lux: lux, band: band_3};

endmodule

// ----- hdl/dual_channel_lux_calculator.sv -----
// Channel   Handshake       Fields
// input     push / full     broadband_count[15:0], infrared_count[15:0]
// result    pop / empty     lux_fixed[20:0], ratio_band[2:0]
//
// One request is accepted per clock while full is low. The divider resolves one
// quotient bit per stage, ahead of the middle queue, back end and result queue.
// Reset clears valid bits, queue pointers and credit counters.
// full rises only when the divider and the middle queue together hold as many
// requests as that queue can store; a stalled result side fills the result
// queue first and then the middle queue before full is raised.

module dual_channel_lux_calculator #(
  parameter int RATIO_FRAC_BITS = dclc_pkg::RATIO_FRAC_BITS_DEF,
  parameter int LUX_FRAC_BITS   = dclc_pkg::LUX_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [dclc_pkg::COUNT_W-1:0] broadband_count,
  input  logic [dclc_pkg::COUNT_W-1:0] infrared_count,
  output logic                         empty,
  input  logic                         pop,
  output logic [dclc_pkg::LUX_W-1:0]   lux_fixed,
  output logic [2:0]                   ratio_band
);
  import dclc_pkg::*;

  // The front end is the divider pipeline: an entry register plus one stage
  // per quotient bit. The middle queue is sized so that a full pipeline
  // never overruns it, rounded up to a power of two.
  localparam int QB         = RATIO_FRAC_BITS + 2;
  localparam int FRONT_LAT  = QB + 1;
  localparam int MIDQ_DEPTH = 1 << $clog2(FRONT_LAT + 2);

  // Front end to middle queue.
  logic        fr_valid;
  front_item_t fr_item;
  logic        credit_ret;

  // Middle queue to back end.
  logic        mq_empty;
  front_item_t mq_item;

  // Back end to result queue.
  logic        bk_valid;
  result_t     bk_res;
  result_t     out_res;
  logic        out_taken;

  // The front end divides infrared by broadband and classifies the ratio
  // into a band. Its credit counter tracks every request it has accepted
  // until the back end takes it out of the middle queue, so the divider
  // never has to stall.
  dclc_front #(
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS),
    .QDEPTH         (MIDQ_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .broadband_count(broadband_count),
    .infrared_count (infrared_count),
    .full           (full),
    .credit_ret     (credit_ret),
    .item_valid     (fr_valid),
    .item           (fr_item)
  );

  dclc_queue #(
    .WIDTH($bits(front_item_t)),
    .DEPTH(MIDQ_DEPTH)
  ) u_midq (
    .clk  (clk),
    .rst  (rst),
    .push (fr_valid),
    .wdata(fr_item),
    .pop  (credit_ret),
    .rdata(mq_item),
    .empty(mq_empty)
  );

  // The back end reads the power table, forms the band's formula and
  // scales the Q32 accumulator to the lux format. It takes a request out of
  // the middle queue only while it holds a free slot in the result queue.
  dclc_back #(
    .LUX_FRAC_BITS(LUX_FRAC_BITS),
    .QDEPTH       (OUTQ_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .src_empty(mq_empty),
    .src_item (mq_item),
    .src_pop  (credit_ret),
    .res_ret  (out_taken),
    .res_valid(bk_valid),
    .res      (bk_res)
  );

  // The result queue decouples the back end from the consumer; its head
  // is on the result ports while empty is low.
  dclc_queue #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUTQ_DEPTH)
  ) u_outq (
    .clk  (clk),
    .rst  (rst),
    .push (bk_valid),
    .wdata(bk_res),
    .pop  (pop),
    .rdata(out_res),
    .empty(empty)
  );

  assign out_taken  = pop && !empty;
  assign lux_fixed  = out_res.lux;
  assign ratio_band = out_res.band;

endmodule

// ----- hdl/dclc_checker.sv -----
`include "assert_macros.svh"

module dclc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [dclc_pkg::LUX_W-1:0]   lux_fixed,
  input logic [2:0]                   ratio_band
);
  import dclc_pkg::*;

  logic off_band;

  assign off_band = ratio_band inside {3'(BAND_ABOVE), 3'(BAND_DARK)};

  // Reset drains both queues and returns all credits.
  `DCLC_ASSERT_RST(a_reset_empty, rst |=> empty)
  `DCLC_ASSERT_RST(a_reset_not_full, rst |=> !full)

  // Requests outside the four formula bands always report zero lux.
  `DCLC_ASSERT(a_zero_outside_bands, !empty && off_band |-> lux_fixed == '0)

  // A result that is not taken stays on the ports unchanged.
  `DCLC_ASSERT(a_result_holds, !empty && !pop |=> !empty && $stable(lux_fixed) && $stable(ratio_band))

endmodule

bind dual_channel_lux_calculator dclc_checker u_checker (.*);
